// ===== src/eq2h_pkg.sv =====
// Package: widths, constants, CORDIC angle table and arithmetic helpers.
`default_nettype none
package eq2h_pkg;
   localparam int ANG_W              = 32;
   localparam int ROT_W              = 34;
   localparam int VEC_W              = 36;
   localparam int CORDIC_STAGES_DEF  = 32;
   localparam int ANG_TABLE_LEN      = 40;

   localparam logic signed [VEC_W-1:0] QUARTER_TURN = VEC_W'(64'sd1073741824);
   localparam logic signed [VEC_W-1:0] HALF_TURN    = VEC_W'(64'sd2147483648);
   localparam logic signed [VEC_W-1:0] GAIN_Q30     = VEC_W'(64'sd652032874);

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] z;
      logic                    flip;
   } rot_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
      logic                    zero;
   } vec_type;

   function automatic logic [ANG_W-1:0] micro_angle(input int idx);
      logic [ANG_W-1:0] a;
      case (idx)
         0:       a = 32'd536870912;
         1:       a = 32'd316933406;
         2:       a = 32'd167458907;
         3:       a = 32'd85004756;
         4:       a = 32'd42667331;
         5:       a = 32'd21354465;
         6:       a = 32'd10679838;
         7:       a = 32'd5340245;
         8:       a = 32'd2670163;
         9:       a = 32'd1335087;
         10:      a = 32'd667544;
         11:      a = 32'd333772;
         12:      a = 32'd166886;
         13:      a = 32'd83443;
         14:      a = 32'd41722;
         15:      a = 32'd20861;
         16:      a = 32'd10430;
         17:      a = 32'd5215;
         18:      a = 32'd2608;
         19:      a = 32'd1304;
         20:      a = 32'd652;
         21:      a = 32'd326;
         22:      a = 32'd163;
         23:      a = 32'd81;
         24:      a = 32'd41;
         25:      a = 32'd20;
         26:      a = 32'd10;
         27:      a = 32'd5;
         28:      a = 32'd3;
         29:      a = 32'd1;
         30:      a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   function automatic logic signed [VEC_W-1:0] qmul(input logic signed [VEC_W-1:0] a,
                                                    input logic signed [VEC_W-1:0] b);
      logic signed [2*VEC_W-1:0] p;
      p = a * b;
      return p[VEC_W+29:30];
   endfunction

   function automatic rot_type rot_pre(input logic [ANG_W-1:0] ang);
      rot_type r;
      logic signed [ROT_W-1:0] q;
      logic signed [ROT_W-1:0] h;
      q = ROT_W'(QUARTER_TURN);
      h = ROT_W'(HALF_TURN);
      r.x    = ROT_W'(GAIN_Q30);
      r.y    = '0;
      r.z    = ROT_W'($signed(ang));
      r.flip = 1'b0;
      if (r.z > q) begin
         r.z    = r.z - h;
         r.flip = 1'b1;
      end else if (r.z < -q) begin
         r.z    = r.z + h;
         r.flip = 1'b1;
      end
      return r;
   endfunction

   function automatic vec_type vec_pre(input logic signed [VEC_W-1:0] x,
                                       input logic signed [VEC_W-1:0] y);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.x    = x;
      v.y    = y;
      v.z    = '0;
      if (x < 0) begin
         v.x = -x;
         v.y = -y;
         v.z = HALF_TURN;
      end
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== src/eq2h_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface eq2h_req_if;
   logic               valid;
   logic               ready;
   logic        [31:0] right_ascension;
   logic signed [31:0] declination;
   logic        [31:0] sidereal_time;
   modport source(output valid, right_ascension, declination, sidereal_time, input ready);
   modport sink(input valid, right_ascension, declination, sidereal_time, output ready);
endinterface

interface eq2h_rsp_if;
   logic               valid;
   logic               ready;
   logic        [31:0] azimuth;
   logic signed [31:0] altitude;
   modport source(output valid, azimuth, altitude, input ready);
   modport sink(input valid, azimuth, altitude, output ready);
endinterface
`default_nettype wire

// ===== src/equatorial_to_horizontal.sv =====
// Top level: equatorial to horizontal conversion pipeline.
// Converts (right ascension, declination, sidereal time) to (azimuth, altitude) for the
// latitude held in the csr register; all angles are 2^-32 turn. The datapath is a fully
// pipelined chain of CORDIC cells: three rotation chains for the sines and cosines, two
// multiply stages, a vectoring chain for azimuth and horizontal magnitude, and a second
// vectoring chain for altitude. One transaction is accepted per cycle while the response
// channel is not stalled. A stall on the response channel holds the whole pipeline.
// Write the latitude only while idle.
`default_nettype none
module equatorial_to_horizontal import eq2h_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   eq2h_req_if.sink                req_chan,
   eq2h_rsp_if.source              rsp_chan,
   input  wire logic               csr_we,
   input  wire logic signed [31:0] csr_wdata
);
   localparam int N   = CORDIC_STAGES;
   localparam int LAT = 3 * N + 8;

   logic                    en;
   logic signed [31:0]      lat_ff;
   logic [LAT-1:0]          vld_ff;

   rot_type                 ha_c [N+1];
   rot_type                 dc_c [N+1];
   rot_type                 la_c [N+1];

   logic signed [VEC_W-1:0] sh_ff, ch_ff, sd_ff, cd_ff, sp_ff, cp_ff;
   logic signed [VEC_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff, yv_ff, ch1_ff, cd1_ff;
   logic signed [VEC_W-1:0] salt_ff, xv_ff, yv2_ff;

   vec_type                 v1_c [N+1];
   logic signed [VEC_W-1:0] sa_ff [N+1];
   logic signed [VEC_W-1:0] horiz_ff, sag_ff;
   logic [31:0]             azg_ff;
   vec_type                 v2_c [N+1];
   logic [31:0]             az_ff [N+1];
   logic signed [VEC_W-1:0] az_sum;
   logic signed [VEC_W-1:0] alt_raw;
   logic signed [31:0]      alt_in;
   logic [31:0]             azo_ff;
   logic signed [31:0]      alto_ff;

   assign en             = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = vld_ff[LAT-1];
   assign rsp_chan.azimuth  = azo_ff;
   assign rsp_chan.altitude = alto_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
         vld_ff <= '0;
      end else begin
         if (csr_we) lat_ff <= csr_wdata;
         if (en) vld_ff <= {vld_ff[LAT-2:0], req_chan.valid};
      end
   end

   // rotation chain
   always_ff @(posedge clock) begin
      if (en) begin
         ha_c[0] <= rot_pre(req_chan.sidereal_time - req_chan.right_ascension);
         dc_c[0] <= rot_pre(req_chan.declination);
         la_c[0] <= rot_pre(lat_ff);
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      eq2h_rot_cell #(.STAGE(i)) u_ha (.clock, .en, .cur(ha_c[i]), .nxt_ff(ha_c[i+1]));
      eq2h_rot_cell #(.STAGE(i)) u_dc (.clock, .en, .cur(dc_c[i]), .nxt_ff(dc_c[i+1]));
      eq2h_rot_cell #(.STAGE(i)) u_la (.clock, .en, .cur(la_c[i]), .nxt_ff(la_c[i+1]));
   end

   // sign fix, products and azimuth vectoring chain input
   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff <= ha_c[N].flip ? -VEC_W'(ha_c[N].y) : VEC_W'(ha_c[N].y);
         ch_ff <= ha_c[N].flip ? -VEC_W'(ha_c[N].x) : VEC_W'(ha_c[N].x);
         sd_ff <= dc_c[N].flip ? -VEC_W'(dc_c[N].y) : VEC_W'(dc_c[N].y);
         cd_ff <= dc_c[N].flip ? -VEC_W'(dc_c[N].x) : VEC_W'(dc_c[N].x);
         sp_ff <= la_c[N].flip ? -VEC_W'(la_c[N].y) : VEC_W'(la_c[N].y);
         cp_ff <= la_c[N].flip ? -VEC_W'(la_c[N].x) : VEC_W'(la_c[N].x);

         p1_ff  <= qmul(sp_ff, sd_ff);
         p2_ff  <= qmul(cp_ff, cd_ff);
         p3_ff  <= qmul(ch_ff, sp_ff);
         p4_ff  <= qmul(sd_ff, cp_ff);
         yv_ff  <= qmul(sh_ff, cd_ff);
         ch1_ff <= ch_ff;
         cd1_ff <= cd_ff;

         salt_ff <= p1_ff + qmul(p2_ff, ch1_ff);
         xv_ff   <= qmul(p3_ff, cd1_ff) - p4_ff;
         yv2_ff  <= yv_ff;

         v1_c[0]  <= vec_pre(xv_ff, yv2_ff);
         sa_ff[0] <= salt_ff;
      end
   end

   // azimuth vectoring chain
   for (genvar i = 0; i < N; i++) begin : g_vec1
      eq2h_vec_cell #(.STAGE(i)) u_v (.clock, .en, .cur(v1_c[i]), .nxt_ff(v1_c[i+1]));
      always_ff @(posedge clock) begin
         if (en) sa_ff[i+1] <= sa_ff[i];
      end
   end

   assign az_sum = (v1_c[N].zero ? '0 : v1_c[N].z) + HALF_TURN;

   always_ff @(posedge clock) begin
      if (en) begin
         horiz_ff <= v1_c[N].zero ? '0 : qmul(v1_c[N].x, GAIN_Q30);
         sag_ff   <= sa_ff[N];
         azg_ff   <= az_sum[31:0];
         v2_c[0]  <= vec_pre(horiz_ff, sag_ff);
         az_ff[0] <= azg_ff;
      end
   end

   // altitude vectoring chain
   for (genvar i = 0; i < N; i++) begin : g_vec2
      eq2h_vec_cell #(.STAGE(i)) u_v (.clock, .en, .cur(v2_c[i]), .nxt_ff(v2_c[i+1]));
      always_ff @(posedge clock) begin
         if (en) az_ff[i+1] <= az_ff[i];
      end
   end

   always_comb begin
      alt_raw = v2_c[N].zero ? '0 : v2_c[N].z;
      if (alt_raw > QUARTER_TURN)       alt_in = 32'(QUARTER_TURN);
      else if (alt_raw < -QUARTER_TURN) alt_in = -32'(QUARTER_TURN);
      else                              alt_in = alt_raw[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         azo_ff  <= az_ff[N];
         alto_ff <= alt_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/eq2h_rot_cell.sv =====
// Rotation-mode CORDIC cell: one micro-rotation per cycle while en is high.
`default_nettype none
module eq2h_rot_cell import eq2h_pkg::*; #(
   parameter int STAGE = 0
) (
   input  wire logic    clock,
   input  wire logic    en,
   input  wire rot_type cur,
   output rot_type      nxt_ff
);
   localparam logic signed [ROT_W-1:0] ANG = {(ROT_W-ANG_W)'(0), micro_angle(STAGE)};

   rot_type                 nxt_in;
   logic signed [ROT_W-1:0] dx;
   logic signed [ROT_W-1:0] dy;

   always_comb begin
      dx = cur.y >>> STAGE;
      dy = cur.x >>> STAGE;
      nxt_in = cur;
      if (cur.z >= 0) begin
         nxt_in.x = cur.x - dx;
         nxt_in.y = cur.y + dy;
         nxt_in.z = cur.z - ANG;
      end else begin
         nxt_in.x = cur.x + dx;
         nxt_in.y = cur.y - dy;
         nxt_in.z = cur.z + ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) nxt_ff <= nxt_in;
   end
endmodule
`default_nettype wire

// ===== src/eq2h_vec_cell.sv =====
// Vectoring-mode CORDIC cell: one micro-rotation per cycle while en is high.
`default_nettype none
module eq2h_vec_cell import eq2h_pkg::*; #(
   parameter int STAGE = 0
) (
   input  wire logic    clock,
   input  wire logic    en,
   input  wire vec_type cur,
   output vec_type      nxt_ff
);
   localparam logic signed [VEC_W-1:0] ANG = {(VEC_W-ANG_W)'(0), micro_angle(STAGE)};

   vec_type                 nxt_in;
   logic signed [VEC_W-1:0] dx;
   logic signed [VEC_W-1:0] dy;

   always_comb begin
      dx = cur.y >>> STAGE;
      dy = cur.x >>> STAGE;
      nxt_in = cur;
      if (cur.y > 0) begin
         nxt_in.x = cur.x + dx;
         nxt_in.y = cur.y - dy;
         nxt_in.z = cur.z + ANG;
      end else begin
         nxt_in.x = cur.x - dx;
         nxt_in.y = cur.y + dy;
         nxt_in.z = cur.z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) nxt_ff <= nxt_in;
   end
endmodule
`default_nettype wire
